// ===== rtl/sbt_pkg.sv =====
// Shared types and constants for the sorted breakpoint table.
// Used by sbt_cell and sorted_breakpoint_table. No dependencies.
package sbt_pkg;

    localparam int TIME_W = 32;
    localparam int PAY_W  = 32;
    localparam int ACT_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [ACT_W-1:0] ACT_SPLIT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Broadcast controls from the sequencer to every cell.
    typedef struct packed {
        logic cmp_en;   // capture the compare flag against the key
        logic shift_en; // perform an insert at the upper bound
        logic wr_en;    // payload write to the addressed cell
    } cell_ctrl_t;

endpackage

// ===== rtl/sbt_cell.sv =====
// One cell of the breakpoint chain: a breakpoint slot, a segment payload slot
// and the registered "breakpoint <= key" flag. Depends on sbt_pkg.
module sbt_cell #(
    parameter int IDX    = 0,
    parameter int IDX_W  = 7,
    parameter bit HAS_BP = 1'b1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sbt_pkg::cell_ctrl_t       ctrl,
    input  logic [sbt_pkg::TIME_W-1:0] key,
    input  logic [IDX_W-1:0]          count,
    input  logic [IDX_W-1:0]          wr_index,
    input  logic [sbt_pkg::PAY_W-1:0] wr_data,
    input  logic                      prev_le,
    input  logic [sbt_pkg::TIME_W-1:0] prev_bp,
    input  logic [sbt_pkg::PAY_W-1:0] prev_seg,
    output logic                      le,
    output logic                      hit,
    output logic [sbt_pkg::TIME_W-1:0] bp_out,
    output logic [sbt_pkg::PAY_W-1:0] seg_out
);

    logic [sbt_pkg::PAY_W-1:0] seg_reg;
    logic                      shift;

    // The flags form a thermometer, so the upper bound is where a set flag
    // is followed by a clear one.
    assign hit   = prev_le && !le;
    assign shift = !prev_le;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= '0;
        end
        else if (ctrl.shift_en && shift)
        begin
            seg_reg <= prev_seg;
        end
        else if (ctrl.wr_en && (wr_index == IDX_W'(IDX)))
        begin
            seg_reg <= wr_data;
        end
    end

    assign seg_out = seg_reg;

    generate
        if (HAS_BP)
        begin : g_bp
            logic [sbt_pkg::TIME_W-1:0] bp_reg;
            logic                       le_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    le_reg <= 1'b0;
                end
                else if (ctrl.cmp_en)
                begin
                    le_reg <= (IDX_W'(IDX) < count) && (bp_reg <= key);
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctrl.shift_en)
                begin
                    if (hit)
                    begin
                        bp_reg <= key;
                    end
                    else if (shift)
                    begin
                        bp_reg <= prev_bp;
                    end
                end
            end

            assign le     = le_reg;
            assign bp_out = bp_reg;
        end
        else
        begin : g_no_bp
            assign le     = 1'b0;
            assign bp_out = '0;
        end
    endgenerate

endmodule

// ===== rtl/sorted_breakpoint_table.sv =====
// Sorted breakpoint table: a chain of MAX_BREAKPOINTS+1 cells that compare in parallel.
// Each transaction: the accept cycle registers every cell's compare; then, once the output
// register is free or being read, the cells insert or write and the result register loads.
// No new item is accepted until then, and the result waits in the output register if stalled.
// Reset (rst_n, asynchronous, active low) empties the table and leaves one segment with
// payload 0; it accepts a transaction as soon as reset is released.
module sorted_breakpoint_table #(
    parameter int MAX_BREAKPOINTS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // time_req, seg_index, payload (low to high), zero padded to whole bytes
    input  logic [((2*sbt_pkg::TIME_W + $clog2(MAX_BREAKPOINTS+1) + 7) / 8) * 8 - 1:0] s_tdata,
    // action
    input  logic [sbt_pkg::ACT_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // index, breakpoint before, breakpoint after, segment payload (low to high),
    // zero padded to whole bytes
    output logic [((3*sbt_pkg::TIME_W + $clog2(MAX_BREAKPOINTS+1) + 7) / 8) * 8 - 1:0] m_tdata,
    // status
    output logic [sbt_pkg::STAT_W-1:0] m_tuser
);

    localparam int N      = MAX_BREAKPOINTS;
    localparam int IDX_W  = $clog2(MAX_BREAKPOINTS + 1);
    localparam int TW     = sbt_pkg::TIME_W;
    localparam int PW     = sbt_pkg::PAY_W;
    localparam int OUT_W  = ((3*TW + IDX_W + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - (3*TW + IDX_W);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                      state_reg, state_next;
    logic [IDX_W-1:0]          count_reg;
    logic [sbt_pkg::ACT_W-1:0] act_reg;
    logic [TW-1:0]             time_reg;
    logic [IDX_W-1:0]          sidx_reg;
    logic [PW-1:0]             pay_reg;

    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic [TW-1:0]             out_before_reg;
    logic [TW-1:0]             out_after_reg;
    logic [PW-1:0]             out_pay_reg;
    logic [sbt_pkg::STAT_W-1:0] out_stat_reg;

    logic                      accept;
    logic                      exec_go;
    logic                      full;
    logic                      wr_in_range;
    sbt_pkg::cell_ctrl_t       ctrl;
    logic [TW-1:0]             key;

    logic [N:0]                le;
    logic [N:0]                hit;
    logic [TW-1:0]             bp   [0:N];
    logic [PW-1:0]             seg  [0:N];

    logic [IDX_W-1:0]          pos;
    logic [TW-1:0]             sel_before;
    logic [TW-1:0]             sel_at;
    logic [PW-1:0]             sel_seg;

    logic [IDX_W-1:0]          res_index;
    logic [TW-1:0]             res_before;
    logic [TW-1:0]             res_after;
    logic [PW-1:0]             res_pay;
    logic [sbt_pkg::STAT_W-1:0] res_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    assign full        = (count_reg == IDX_W'(N));
    assign wr_in_range = (sidx_reg <= count_reg);

    // Cells compare against the incoming time while idle and insert the held one.
    assign key = (state_reg == ST_IDLE) ? s_tdata[TW-1:0] : time_reg;

    assign ctrl.cmp_en   = accept;
    assign ctrl.shift_en = exec_go && (act_reg == sbt_pkg::ACT_SPLIT) && !full;
    assign ctrl.wr_en    = exec_go && (act_reg == sbt_pkg::ACT_WRITE) && wr_in_range;

    genvar gi;
    generate
        for (gi = 0; gi <= N; gi++)
        begin : g_cell
            logic          prev_le_w;
            logic [TW-1:0] prev_bp_w;
            logic [PW-1:0] prev_seg_w;

            if (gi == 0)
            begin : g_head
                assign prev_le_w  = 1'b1;
                assign prev_bp_w  = '0;
                assign prev_seg_w = '0;
            end
            else
            begin : g_link
                assign prev_le_w  = le[gi-1];
                assign prev_bp_w  = bp[gi-1];
                assign prev_seg_w = seg[gi-1];
            end

            sbt_cell #(
                .IDX    (gi),
                .IDX_W  (IDX_W),
                .HAS_BP (gi < N)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .key      (key),
                .count    (count_reg),
                .wr_index (sidx_reg),
                .wr_data  (pay_reg),
                .prev_le  (prev_le_w),
                .prev_bp  (prev_bp_w),
                .prev_seg (prev_seg_w),
                .le       (le[gi]),
                .hit      (hit[gi]),
                .bp_out   (bp[gi]),
                .seg_out  (seg[gi])
            );
        end
    endgenerate

    // One-hot selects: hit marks the upper bound, the last set flag marks the
    // breakpoint just before it.
    always_comb
    begin
        pos        = '0;
        sel_before = '0;
        sel_at     = '0;
        sel_seg    = '0;
        for (int i = 0; i <= N; i++)
        begin
            if (hit[i])
            begin
                pos     = pos | IDX_W'(i);
                sel_seg = sel_seg | seg[i];
            end
        end
        for (int i = 0; i < N; i++)
        begin
            if (hit[i])
            begin
                sel_at = sel_at | bp[i];
            end
            if (le[i] && !le[i+1])
            begin
                sel_before = sel_before | bp[i];
            end
        end
    end

    always_comb
    begin
        res_index  = '0;
        res_before = '0;
        res_after  = '0;
        res_pay    = '0;
        res_stat   = sbt_pkg::STAT_OK;
        unique case (act_reg)
            sbt_pkg::ACT_SPLIT:
            begin
                res_index = pos;
                if (full)
                begin
                    res_stat = sbt_pkg::STAT_FULL;
                end
            end
            sbt_pkg::ACT_LOOKUP:
            begin
                res_index = pos;
                res_pay   = sel_seg;
                if (pos != '0)
                begin
                    res_before = sel_before;
                    // Past the last breakpoint the after value clamps to the last one.
                    res_after  = (pos < count_reg) ? sel_at : sel_before;
                end
            end
            sbt_pkg::ACT_WRITE:
            begin
                res_index = sidx_reg;
                if (wr_in_range)
                begin
                    res_pay = pay_reg;
                end
                else
                begin
                    res_stat = sbt_pkg::STAT_RANGE;
                end
            end
            default:
            begin
                res_index = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.shift_en)
            begin
                count_reg <= count_reg + IDX_W'(1);
            end
            if (exec_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= s_tuser;
            time_reg <= s_tdata[TW-1:0];
            sidx_reg <= s_tdata[TW +: IDX_W];
            pay_reg  <= s_tdata[TW + IDX_W +: PW];
        end
        if (exec_go)
        begin
            out_index_reg  <= res_index;
            out_before_reg <= res_before;
            out_after_reg  <= res_after;
            out_pay_reg    <= res_pay;
            out_stat_reg   <= res_stat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_stat_reg;
    generate
        if (OUT_PAD > 0)
        begin : g_out_pad
            assign m_tdata = {{OUT_PAD{1'b0}}, out_pay_reg, out_after_reg,
                              out_before_reg, out_index_reg};
        end
        else
        begin : g_out_nopad
            assign m_tdata = {out_pay_reg, out_after_reg, out_before_reg, out_index_reg};
        end
    endgenerate

endmodule
